>>> rtl/smt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the softmax with temperature block.
// No dependencies.
package smt_pkg;

  localparam int LOGIT_W = 24;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int INV_W   = 16;
  localparam int PROB_W  = 17;
  localparam int SUM_W   = 23;
  localparam int ACC_W   = 25;
  localparam int MAG_W   = 17;
  localparam int EXP_BITS = 17;

  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_WARN   = 2'd1;
  localparam logic [1:0] STATUS_CRIT   = 2'd2;

  localparam logic [24:0] RANGE_WARN_Q12 = 25'd819200;
  localparam logic [24:0] RANGE_CRIT_Q12 = 25'd4096000;
  localparam logic [28:0] CLAMP_Q12      = 29'd122880;
  localparam logic [INV_W-1:0] INV_TEMP_RESET = 16'd4096;

  typedef struct packed {
    logic [CNT_W-1:0]          len;
    logic signed [LOGIT_W-1:0] vmax;
    logic [1:0]                status;
    logic                      bank;
  } job_t;

  function automatic logic [23:0] exp_coef(input logic [4:0] b);
    case (b)
      5'd0:    exp_coef = 24'd16773120;
      5'd1:    exp_coef = 24'd16769026;
      5'd2:    exp_coef = 24'd16760840;
      5'd3:    exp_coef = 24'd16744480;
      5'd4:    exp_coef = 24'd16711808;
      5'd5:    exp_coef = 24'd16646655;
      5'd6:    exp_coef = 24'd16517109;
      5'd7:    exp_coef = 24'd16261035;
      5'd8:    exp_coef = 24'd15760736;
      5'd9:    exp_coef = 24'd14805841;
      5'd10:   exp_coef = 24'd13066109;
      5'd11:   exp_coef = 24'd10175896;
      5'd12:   exp_coef = 24'd6171993;
      5'd13:   exp_coef = 24'd2270549;
      5'd14:   exp_coef = 24'd307285;
      5'd15:   exp_coef = 24'd5628;
      5'd16:   exp_coef = 24'd2;
      default: exp_coef = 24'd0;
    endcase
  endfunction

endpackage

>>> rtl/smt_ram.sv
`timescale 1ns / 1ps
// Generic one-write one-read RAM with registered read data.
// No dependencies.
module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/smt_jobq.sv
`timescale 1ns / 1ps
// Two-entry queue of vector jobs between the load front and the compute back.
// Depends on smt_pkg.
module smt_jobq import smt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic qfull,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t       e0;
  job_t       e1;
  logic [1:0] cnt;

  assign qfull      = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head       = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) e0 <= push_job;
          else e1 <= push_job;
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          e0 <= e1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            e0 <= push_job;
          end else begin
            e0 <= e1;
            e1 <= push_job;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/smt_front.sv
`timescale 1ns / 1ps
// Load front: stores logits into the banked buffer, tracks max and min,
// and posts one job per vector. Depends on smt_pkg.
module smt_front import smt_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                      last_in,
  output logic                      we,
  output logic [CNT_W-1:0]          waddr,
  output logic                      job_push,
  output job_t                      job
);

  logic [CNT_W-1:0]          count;
  logic signed [LOGIT_W-1:0] vmax;
  logic signed [LOGIT_W-1:0] vmin;
  logic                      bank;
  logic signed [LOGIT_W-1:0] vmax_next;
  logic signed [LOGIT_W-1:0] vmin_next;
  logic [CNT_W-1:0]          count_inc;
  logic [24:0]               range;
  logic                      done;

  always_comb begin
    if (count == '0) begin
      vmax_next = logit;
      vmin_next = logit;
    end else begin
      vmax_next = (logit > vmax) ? logit : vmax;
      vmin_next = (logit < vmin) ? logit : vmin;
    end
    count_inc = count + CNT_W'(1);
    done      = last_in || (count_inc == CNT_W'(MAX_LEN));
    range     = 25'({vmax_next[LOGIT_W-1], vmax_next} - {vmin_next[LOGIT_W-1], vmin_next});
    job.len   = count_inc;
    job.vmax  = vmax_next;
    job.bank  = bank;
    if (range > RANGE_CRIT_Q12) job.status = STATUS_CRIT;
    else if (range > RANGE_WARN_Q12) job.status = STATUS_WARN;
    else job.status = STATUS_NORMAL;
  end

  assign we       = accept;
  assign waddr    = bank ? CNT_W'(count + CNT_W'(MAX_LEN)) : count;
  assign job_push = accept && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bank  <= 1'b0;
      vmax  <= '0;
      vmin  <= '0;
    end else if (accept) begin
      vmax <= vmax_next;
      vmin <= vmin_next;
      if (done) begin
        count <= '0;
        bank  <= ~bank;
      end else begin
        count <= count_inc;
      end
    end
  end

endmodule

>>> rtl/smt_back.sv
`timescale 1ns / 1ps
// Compute back: per job, scaled exponent of every element, running sum,
// then one divide per element into the output word. Depends on smt_pkg, smt_ram.
module smt_back import smt_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [INV_W-1:0]          inv_temp,
  input  logic                      job_valid,
  input  job_t                      job_in,
  output logic                      job_pop,
  output logic [CNT_W-1:0]          lraddr,
  input  logic signed [LOGIT_W-1:0] lrdata,
  input  logic                      pop,
  output logic                      empty,
  output logic [PROB_W-1:0]         probability,
  output logic [1:0]                range_status,
  output logic                      last_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_AMUL = 4'd2;
  localparam logic [3:0] S_ASCL = 4'd3;
  localparam logic [3:0] S_AEXP = 4'd4;
  localparam logic [3:0] S_AWR  = 4'd5;
  localparam logic [3:0] S_BRD  = 4'd6;
  localparam logic [3:0] S_BLD  = 4'd7;
  localparam logic [3:0] S_BDIV = 4'd8;
  localparam logic [3:0] S_BOUT = 4'd9;

  localparam int NUM_W = 33;

  logic [3:0]        state;
  job_t              job;
  logic [CNT_W-1:0]  idx;
  logic [SUM_W-1:0]  sum;
  logic [40:0]       prod;
  logic [MAG_W-1:0]  mag;
  logic [ACC_W-1:0]  acc;
  logic [4:0]        bit_idx;
  logic [NUM_W-1:0]  numq;
  logic [SUM_W:0]    rem;
  logic [5:0]        step;
  logic              out_valid;

  logic [24:0]       diff;
  logic [28:0]       mag_full;
  logic [48:0]       acc_prod;
  logic [ACC_W-1:0]  acc_step;
  logic [ACC_W-1:0]  exp_round;
  logic [PROB_W-1:0] exp_val;
  logic [PROB_W-1:0] erdata;
  logic [SUM_W:0]    rem_sh;
  logic              rem_ge;
  logic              slot_free;

  smt_ram #(.WIDTH(PROB_W), .DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_exp_ram (
    .clk  (clk),
    .we   (state == S_AWR),
    .waddr(idx[IDX_W-1:0]),
    .wdata(exp_val),
    .raddr(idx[IDX_W-1:0]),
    .rdata(erdata)
  );

  always_comb begin
    diff      = 25'({job.vmax[LOGIT_W-1], job.vmax} - {lrdata[LOGIT_W-1], lrdata});
    mag_full  = 29'((prod + 41'd2048) >> 12);
    acc_prod  = acc * exp_coef(bit_idx);
    acc_step  = ACC_W'((acc_prod + 49'd8388608) >> 24);
    exp_round = acc + ACC_W'(128);
    exp_val   = exp_round[24:8];
    rem_sh    = {rem[SUM_W-1:0], numq[NUM_W-1]};
    rem_ge    = rem_sh >= {1'b0, sum};
    slot_free = !out_valid || pop;
  end

  assign lraddr       = job.bank ? CNT_W'(idx + CNT_W'(MAX_LEN)) : idx;
  assign job_pop      = (state == S_BOUT) && slot_free && (idx + CNT_W'(1) == job.len);
  assign empty        = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            idx   <= '0;
            sum   <= '0;
            state <= S_ARD;
          end
        end
        S_ARD: state <= S_AMUL;
        S_AMUL: begin
          prod  <= 41'(diff * inv_temp);
          state <= S_ASCL;
        end
        S_ASCL: begin
          mag     <= (mag_full > CLAMP_Q12) ? MAG_W'(CLAMP_Q12) : mag_full[MAG_W-1:0];
          acc     <= ACC_W'(1) << 24;
          bit_idx <= '0;
          state   <= S_AEXP;
        end
        S_AEXP: begin
          if (mag[bit_idx]) acc <= acc_step;
          if (bit_idx == 5'(EXP_BITS - 1)) state <= S_AWR;
          else bit_idx <= bit_idx + 5'd1;
        end
        S_AWR: begin
          sum <= sum + SUM_W'(exp_val);
          if (idx + CNT_W'(1) == job.len) begin
            idx   <= '0;
            state <= S_BRD;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_ARD;
          end
        end
        S_BRD: state <= S_BLD;
        S_BLD: begin
          numq  <= {erdata, 16'd0} + NUM_W'(sum >> 1);
          rem   <= '0;
          step  <= '0;
          state <= S_BDIV;
        end
        S_BDIV: begin
          rem  <= rem_ge ? (rem_sh - {1'b0, sum}) : rem_sh;
          numq <= {numq[NUM_W-2:0], rem_ge};
          if (step == 6'(NUM_W - 1)) state <= S_BOUT;
          else step <= step + 6'd1;
        end
        S_BOUT: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            probability  <= numq[PROB_W-1:0];
            range_status <= job.status;
            last_out     <= (idx + CNT_W'(1) == job.len);
            if (idx + CNT_W'(1) == job.len) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_BRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/softmax_with_temperature.sv
`timescale 1ns / 1ps
// Top level of the softmax with temperature block: front, job queue, back.
// Depends on smt_pkg, smt_ram, smt_jobq, smt_front, smt_back.
//
// Push one signed Q11.12 logit per word, last_in on the final one (a vector
// of MAX_LEN words ends by itself). A word is taken while push is high and
// full is low. When a vector closes, the back works it out: first the
// exponent of every element (one coefficient multiply per magnitude bit over
// 17 bits), then the probability of every element (one quotient bit a cycle
// over 33 bits). The logit buffer has two banks, so the next vector loads
// while the previous one computes; full rises only while a third vector would
// be started. Write the reciprocal temperature through cfg_we/cfg_data only
// while no vector is in flight.
module softmax_with_temperature import smt_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [INV_W-1:0]          cfg_data,
  input  logic                      push,
  output logic                      full,
  input  logic signed [LOGIT_W-1:0] logit,
  input  logic                      last_in,
  output logic                      empty,
  input  logic                      pop,
  output logic [PROB_W-1:0]         probability,
  output logic [1:0]                range_status,
  output logic                      last_out
);

  logic [INV_W-1:0]          inv_temp;
  logic                      accept;
  logic                      lwe;
  logic [CNT_W-1:0]          lwaddr;
  logic [CNT_W-1:0]          lraddr;
  logic signed [LOGIT_W-1:0] lrdata;
  logic                      job_push;
  job_t                      push_job;
  logic                      job_full;
  logic                      job_pop;
  logic                      job_valid;
  job_t                      head;

  always_ff @(posedge clk) begin
    if (rst) inv_temp <= INV_TEMP_RESET;
    else if (cfg_we) inv_temp <= cfg_data;
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  smt_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .logit   (logit),
    .last_in (last_in),
    .we      (lwe),
    .waddr   (lwaddr),
    .job_push(job_push),
    .job     (push_job)
  );

  smt_ram #(.WIDTH(LOGIT_W), .DEPTH(2 * MAX_LEN), .ADDR_W(CNT_W)) u_logit_ram (
    .clk  (clk),
    .we   (lwe),
    .waddr(lwaddr),
    .wdata(logit),
    .raddr(lraddr),
    .rdata(lrdata)
  );

  smt_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .qfull     (job_full),
    .pop       (job_pop),
    .head_valid(job_valid),
    .head      (head)
  );

  smt_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk         (clk),
    .rst         (rst),
    .inv_temp    (inv_temp),
    .job_valid   (job_valid),
    .job_in      (head),
    .job_pop     (job_pop),
    .lraddr      (lraddr),
    .lrdata      (lrdata),
    .pop         (pop),
    .empty       (empty),
    .probability (probability),
    .range_status(range_status),
    .last_out    (last_out)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("job retired with no job pending");
  a_push_room: assert property (@(posedge clk) disable iff (rst) job_push |-> !job_full)
    else $error("job posted into a full queue");

endmodule

>>> tb/softmax_with_temperature_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for softmax_with_temperature: drives logit vectors and
// temperature settings, predicts every probability word and checks it on the result side.
// Depends on smt_pkg and the softmax_with_temperature RTL.
module softmax_with_temperature_test;
  import smt_pkg::*;

  localparam int VEC_MAX   = 64;
  localparam int CYCLE_CAP = 600000;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [1:0]        status;
    logic              last;
  } prob_word_t;

  localparam logic [23:0] EXP_K [17] = '{
    24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480, 24'd16711808, 24'd16646655,
    24'd16517109, 24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
    24'd6171993, 24'd2270549, 24'd307285, 24'd5628, 24'd2};

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [INV_W-1:0]          cfg_data;
  logic                      push;
  logic                      full;
  logic signed [LOGIT_W-1:0] logit;
  logic                      last_in;
  logic                      empty;
  logic                      pop;
  logic [PROB_W-1:0]         probability;
  logic [1:0]                range_status;
  logic                      last_out;

  softmax_with_temperature #(.MAX_LEN(VEC_MAX)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .logit(logit), .last_in(last_in),
    .empty(empty), .pop(pop), .probability(probability),
    .range_status(range_status), .last_out(last_out)
  );

  prob_word_t                pending_probs[$];
  logic signed [LOGIT_W-1:0] vec_logits[VEC_MAX];
  logic [PROB_W-1:0]         vec_exps[VEC_MAX];
  int                        vec_len;
  logic signed [LOGIT_W-1:0] vec_max;
  logic signed [LOGIT_W-1:0] vec_min;
  logic [INV_W-1:0]          inv_temp;
  int                        errors;
  int                        cycles;
  int                        hold_req;
  int                        hold_cnt;
  int                        pop_mode;
  int                        burst_left;
  bit                        no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PROB_W-1:0] exp_of_mag(logic [MAG_W-1:0] mag);
    logic [63:0] acc;
    acc = 64'd1 << 24;
    for (int b = 0; b < 17; b++)
      if (mag[b]) acc = (acc * EXP_K[b] + (64'd1 << 23)) >> 24;
    return PROB_W'((acc + 64'd128) >> 8);
  endfunction

  // Push the whole vector's probability words once it closes.
  task automatic close_vector();
    longint     spread;
    logic [1:0] status;
    logic [63:0] d, m, p;
    logic [SUM_W-1:0] sum;
    prob_word_t w;
    spread = longint'(vec_max) - longint'(vec_min);
    status = spread > 4096000 ? STATUS_CRIT : (spread > 819200 ? STATUS_WARN : STATUS_NORMAL);
    sum = '0;
    for (int i = 0; i < vec_len; i++) begin
      d = 64'(longint'(vec_max) - longint'(vec_logits[i]));
      m = (d * inv_temp + 64'd2048) >> 12;
      if (m > 64'd122880) m = 64'd122880;
      vec_exps[i] = exp_of_mag(MAG_W'(m));
      sum = sum + vec_exps[i];
    end
    for (int i = 0; i < vec_len; i++) begin
      p = (sum == 0) ? 64'd0 : (64'(vec_exps[i]) * 65536 + (sum >> 1)) / sum;
      w.prob = PROB_W'(p);
      w.status = status;
      w.last = (i + 1 == vec_len);
      pending_probs.push_back(w);
    end
    vec_len = 0;
  endtask

  task automatic absorb_logit(logic signed [LOGIT_W-1:0] x, logic last);
    if (vec_len >= VEC_MAX) vec_len = 0;
    if (vec_len == 0) begin
      vec_max = x;
      vec_min = x;
    end else begin
      if (x > vec_max) vec_max = x;
      if (x < vec_min) vec_min = x;
    end
    vec_logits[vec_len] = x;
    vec_len++;
    if (last || vec_len == VEC_MAX) close_vector();
  endtask

  task automatic idle_for(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one word; push is left high so a burst runs back to back.
  task automatic send_word(logic signed [LOGIT_W-1:0] x, logic last);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 6));
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (!push) push <= 1'b1;
    logit <= x;
    last_in <= last;
    do @(posedge clk); while (full);
    absorb_logit(x, last);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_probs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_temp(logic [INV_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    inv_temp = v;
  endtask

  function automatic logic signed [LOGIT_W-1:0] pick_logit(int mode, logic signed [LOGIT_W-1:0] base);
    if (mode == 0) return LOGIT_W'($urandom);
    return base + LOGIT_W'($urandom_range(0, 65536)) - LOGIT_W'(32768);
  endfunction

  task automatic send_vector(int len, int mode, bit closed);
    logic signed [LOGIT_W-1:0] base;
    base = LOGIT_W'($urandom);
    for (int i = 0; i < len; i++)
      send_word(pick_logit(mode, base), closed && (i == len - 1));
  endtask

  task automatic test_directed();
    send_word(24'sd0, 1'b1);
    send_word(24'sh7FFFFF, 1'b0);
    send_word(-24'sh800000, 1'b1);
    send_word(24'sd0, 1'b0);
    send_word(24'sd1024000, 1'b1);
    send_word(24'sd4096, 1'b0);
    send_word(24'sd0, 1'b0);
    send_word(-24'sd4096, 1'b0);
    send_word(24'sd8192, 1'b1);
    send_word(24'sd100, 1'b0);
    send_word(24'sd100, 1'b1);
  endtask

  task automatic test_temperature_extremes();
    logic [INV_W-1:0] temps[3];
    temps = '{16'd0, 16'd1, 16'hFFFF};
    foreach (temps[t]) begin
      write_temp(temps[t]);
      send_word(24'sd40960, 1'b0);
      send_word(-24'sd4096, 1'b0);
      send_word(24'sd4000, 1'b1);
    end
    write_temp(INV_TEMP_RESET);
  endtask

  task automatic test_full_buffer();
    send_vector(VEC_MAX, 1, 1'b0);
    send_vector(3, 0, 1'b1);
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 3000;
    no_gaps = 1'b1;
    repeat (3) send_vector(6, 1, 1'b1);
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int sent;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: write_temp(INV_W'($urandom));
        2: write_temp(16'd1);
        3: write_temp(16'hFFFF);
        4: write_temp(INV_W'($urandom_range(1024, 16384)));
        default: write_temp(INV_TEMP_RESET);
      endcase
      pop_mode = phase % 3;
      no_gaps = (phase == 2);
      sent = 0;
      while (sent < 8) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_vector(len, ($urandom_range(0, 3) == 0) ? 0 : 1, 1'b1);
        sent += len;
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    prob_word_t want;
    if (!rst && pop && !empty) begin
      if (pending_probs.size() == 0) begin
        $display("%0t: unexpected word prob=%0d status=%0d last=%0d",
                 $time, probability, range_status, last_out);
        errors++;
      end else begin
        want = pending_probs.pop_front();
        if (probability !== want.prob) begin
          $display("%0t: probability expected %0d actual %0d", $time, want.prob, probability);
          errors++;
        end
        if (range_status !== want.status) begin
          $display("%0t: range_status expected %0d actual %0d", $time, want.status, range_status);
          errors++;
        end
        if (last_out !== want.last) begin
          $display("%0t: last_out expected %0d actual %0d", $time, want.last, last_out);
          errors++;
        end
      end
    end
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= ($urandom_range(0, 3) != 0);
        1: pop <= 1'b1;
        default: pop <= ((cycles % 11) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    push = 1'b0;
    logit = '0;
    last_in = 1'b0;
    pop = 1'b0;
    errors = 0;
    cycles = 0;
    hold_req = 0;
    hold_cnt = 0;
    pop_mode = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    vec_len = 0;
    vec_max = '0;
    vec_min = '0;
    inv_temp = INV_TEMP_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_temperature_extremes();
    test_full_buffer();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && pending_probs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
